// ===== src/stwa_pkg.sv =====
// ----------------------------------------------------------------------------
// stwa_pkg: shared types and constants of the slot table
// Command, status and slot-entry definitions used by the table, the scan
// compare unit and the key/kind memory.
// ----------------------------------------------------------------------------
package stwa_pkg;

   localparam int unsigned CMD_W    = 3;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned KEY_W    = 16;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned SLOT_W   = 4;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TYPEQ  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] RES_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] RES_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] RES_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] RES_EXHAUSTED = 2'd3;

   localparam logic [KEY_W-1:0] ID_START = 16'd100;
   localparam logic [KEY_W-1:0] ID_MAX   = 16'hFFFF;

   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [KIND_W-1:0] kind;
   } entry_type;

   // compare request handed to the scan compare unit
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [KIND_W-1:0] kind;
      logic [KEY_W-1:0]  key;
      logic              occupied;
      logic              removed;
   } probe_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== src/stwa_ram.sv =====
// ----------------------------------------------------------------------------
// stwa_ram: key and kind store of the slot table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stwa_ram #(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned IDX_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  stwa_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]    rd_addr,
   output stwa_pkg::entry_type rd_data
);

   stwa_pkg::entry_type mem [DEPTH];
   stwa_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/stwa_match.sv =====
// ----------------------------------------------------------------------------
// stwa_match: scan compare unit
// Decide whether the slot under the scan pointer satisfies the command.
// ----------------------------------------------------------------------------
module stwa_match (
   input  stwa_pkg::probe_type probe,
   input  stwa_pkg::entry_type entry,
   output logic                hit
);

   always_comb begin
      hit = 1'b0;
      // insert wants a free slot; delete, lookup and type query an occupied one
      if (probe.cmd == stwa_pkg::CMD_INSERT) begin
         hit = !probe.occupied && !probe.removed;
      end else if (probe.cmd == stwa_pkg::CMD_DELETE ||
                   probe.cmd == stwa_pkg::CMD_LOOKUP) begin
         hit = probe.occupied && (entry.key == probe.key);
      end else if (probe.cmd == stwa_pkg::CMD_TYPEQ) begin
         hit = probe.occupied && (entry.kind == probe.kind);
      end
   end

endmodule

// ===== src/slot_table_with_id_allocation_unit.sv =====
// ----------------------------------------------------------------------------
// slot_table_with_id_allocation_unit: slot table with first-free allocation
// Inserts records into the lowest free slot with a running ID, deletes and
// looks up by ID, answers type queries and clears the table.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                                  | transfer
//   --------+-----------+----------------------------------------+-----------------
//   req     | in        | cmd, type_code, key_id                 | req_valid & ready
//   rsp     | out       | status, slot_index, record_id, type    | rsp_valid & ready
//
// Sequence: a command is accepted, the slots are read in order through the single
// compare unit, which compares each slot behind the registered memory read, and
// the result is written back.  Clear and unknown commands skip the scan.
// Reset clears the slot state bits and loads the ID counter with 100.
// The result waits in an output register; a stalled rsp holds the write
// back, and req_ready stays low until the table is idle again.
// ----------------------------------------------------------------------------
module slot_table_with_id_allocation_unit #(
   parameter int unsigned SLOTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [stwa_pkg::CMD_W-1:0]      req_cmd,
   input  logic [stwa_pkg::KIND_W-1:0]     req_type_code,
   input  logic [stwa_pkg::KEY_W-1:0]      req_key_id,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [stwa_pkg::STATUS_W-1:0]   rsp_status,
   output logic [stwa_pkg::SLOT_W-1:0]     rsp_slot_index,
   output logic [stwa_pkg::KEY_W-1:0]      rsp_record_id,
   output logic [stwa_pkg::KIND_W-1:0]     rsp_record_type
);

   localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

   // sequencer
   stwa_pkg::state_type state_ff, state_in;

   // latched command
   logic [stwa_pkg::CMD_W-1:0]  cmd_ff;
   logic [stwa_pkg::KIND_W-1:0] type_ff;
   logic [stwa_pkg::KEY_W-1:0]  key_ff;

   // scan pointers: issue drives the memory address, cmp follows one behind
   logic [IDX_W-1:0] issue_idx_ff;
   logic [IDX_W-1:0] cmp_idx_ff;
   logic             cmp_valid_ff;

   // first hit
   logic                hit_found_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   stwa_pkg::entry_type hit_entry_ff;

   // slot state: occupied and removed bits, both clear means free
   logic [SLOTS-1:0] occ_ff;
   logic [SLOTS-1:0] rem_ff;

   logic [stwa_pkg::KEY_W-1:0] next_id_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [stwa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [stwa_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [stwa_pkg::KEY_W-1:0]    rsp_id_ff, rsp_id_in;
   logic [stwa_pkg::KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;

   // control
   logic accept;
   logic scanning;
   logic scan_hit;
   logic scan_end;
   logic finish_go;
   logic needs_scan;
   logic insert_ok;
   logic do_delete;
   logic do_clear;

   stwa_pkg::entry_type rd_entry;
   stwa_pkg::entry_type wr_entry;
   stwa_pkg::probe_type probe;
   logic                match;

   logic [IDX_W+stwa_pkg::SLOT_W-1:0] hit_idx_wide;

   // --------------------------------------------------------------------
   // key/kind store and the shared compare unit
   // --------------------------------------------------------------------
   assign wr_entry.key  = next_id_ff;
   assign wr_entry.kind = type_ff;

   stwa_ram #(
      .DEPTH (SLOTS),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (insert_ok),
      .wr_addr (hit_idx_ff),
      .wr_data (wr_entry),
      .rd_addr (issue_idx_ff),
      .rd_data (rd_entry)
   );

   assign probe.cmd      = cmd_ff;
   assign probe.kind     = type_ff;
   assign probe.key      = key_ff;
   assign probe.occupied = occ_ff[cmp_idx_ff];
   assign probe.removed  = rem_ff[cmp_idx_ff];

   stwa_match u_match (
      .probe (probe),
      .entry (rd_entry),
      .hit   (match)
   );

   // --------------------------------------------------------------------
   // sequencer: next state
   // --------------------------------------------------------------------
   assign needs_scan = (req_cmd == stwa_pkg::CMD_INSERT) ||
                       (req_cmd == stwa_pkg::CMD_DELETE) ||
                       (req_cmd == stwa_pkg::CMD_LOOKUP) ||
                       (req_cmd == stwa_pkg::CMD_TYPEQ);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stwa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = needs_scan ? stwa_pkg::ST_SCAN : stwa_pkg::ST_FINISH;
            end
         end
         stwa_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = stwa_pkg::ST_FINISH;
            end
         end
         stwa_pkg::ST_FINISH: begin
            if (finish_go) begin
               state_in = stwa_pkg::ST_IDLE;
            end
         end
         default: state_in = stwa_pkg::ST_IDLE;
      endcase
   end

   // --------------------------------------------------------------------
   // sequencer: outputs
   // --------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      scanning  = 1'b0;
      finish_go = 1'b0;
      unique case (state_ff)
         stwa_pkg::ST_IDLE:   req_ready = 1'b1;
         stwa_pkg::ST_SCAN:   scanning  = 1'b1;
         stwa_pkg::ST_FINISH: finish_go = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   assign accept   = req_valid && req_ready;
   assign scan_hit = scanning && cmp_valid_ff && match;
   // stop at the first hit or once the last slot has been compared
   assign scan_end = scanning && cmp_valid_ff && (match || cmp_idx_ff == LAST);

   // --------------------------------------------------------------------
   // write back and result
   // --------------------------------------------------------------------
   assign hit_idx_wide = {{stwa_pkg::SLOT_W{1'b0}}, hit_idx_ff};

   always_comb begin
      insert_ok     = 1'b0;
      do_delete     = 1'b0;
      do_clear      = 1'b0;
      rsp_status_in = stwa_pkg::RES_NOT_FOUND;
      rsp_slot_in   = '0;
      rsp_id_in     = '0;
      rsp_kind_in   = '0;
      priority if (cmd_ff == stwa_pkg::CMD_INSERT) begin
         priority if (!hit_found_ff) begin
            rsp_status_in = stwa_pkg::RES_FULL;
         end else if (next_id_ff == stwa_pkg::ID_MAX) begin
            rsp_status_in = stwa_pkg::RES_EXHAUSTED;
         end else begin
            insert_ok     = finish_go;
            rsp_status_in = stwa_pkg::RES_OK;
            rsp_slot_in   = hit_idx_wide[stwa_pkg::SLOT_W-1:0];
            rsp_id_in     = next_id_ff;
            rsp_kind_in   = type_ff;
         end
      end else if (cmd_ff == stwa_pkg::CMD_DELETE ||
                   cmd_ff == stwa_pkg::CMD_LOOKUP ||
                   cmd_ff == stwa_pkg::CMD_TYPEQ) begin
         if (hit_found_ff) begin
            do_delete     = finish_go && (cmd_ff == stwa_pkg::CMD_DELETE);
            rsp_status_in = stwa_pkg::RES_OK;
            rsp_slot_in   = hit_idx_wide[stwa_pkg::SLOT_W-1:0];
            rsp_id_in     = hit_entry_ff.key;
            rsp_kind_in   = hit_entry_ff.kind;
         end
      end else if (cmd_ff == stwa_pkg::CMD_CLEAR) begin
         do_clear      = finish_go;
         rsp_status_in = stwa_pkg::RES_OK;
      end else begin
         // unknown command: keep the not-found reply and touch nothing
      end
   end

   // --------------------------------------------------------------------
   // registers
   // --------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stwa_pkg::ST_IDLE;
         cmp_valid_ff <= 1'b0;
         hit_found_ff <= 1'b0;
         occ_ff       <= '0;
         rem_ff       <= '0;
         next_id_ff   <= stwa_pkg::ID_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;

         // start a scan from slot zero
         if (accept) begin
            cmp_valid_ff <= 1'b0;
            hit_found_ff <= 1'b0;
         end else if (scanning) begin
            cmp_valid_ff <= 1'b1;
         end
         if (scan_hit) begin
            hit_found_ff <= 1'b1;
         end

         // slot state updates at write back
         if (do_clear) begin
            occ_ff <= '0;
            rem_ff <= '0;
         end
         if (insert_ok) begin
            occ_ff[hit_idx_ff] <= 1'b1;
            next_id_ff         <= next_id_ff + 16'd1;
         end
         if (do_delete) begin
            occ_ff[hit_idx_ff] <= 1'b0;
            rem_ff[hit_idx_ff] <= 1'b1;
         end

         // hold the result until the transfer
         if (finish_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff       <= req_cmd;
         type_ff      <= req_type_code;
         key_ff       <= req_key_id;
         issue_idx_ff <= '0;
      end else if (scanning) begin
         cmp_idx_ff <= issue_idx_ff;
         if (issue_idx_ff != LAST) begin
            issue_idx_ff <= issue_idx_ff + IDX_W'(1);
         end
      end
      if (scan_hit) begin
         hit_idx_ff   <= cmp_idx_ff;
         hit_entry_ff <= rd_entry;
      end
      if (finish_go) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_kind_ff   <= rsp_kind_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_index  = rsp_slot_ff;
   assign rsp_record_id   = rsp_id_ff;
   assign rsp_record_type = rsp_kind_ff;

endmodule
